// ===== hdl/greedy_coin_change_macros.svh =====
// Assertion macros shared by the greedy coin change RTL.
`ifndef GREEDY_COIN_CHANGE_MACROS_SVH
`define GREEDY_COIN_CHANGE_MACROS_SVH

`ifndef ASSERT_OFF
`define GCC_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GCC_ASSERT_IMPL(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);
`else
`define GCC_ASSERT(label, clk, rst_n, prop, msg)
`define GCC_ASSERT_IMPL(label, clk, rst_n, pre, post, msg)
`endif

`endif

// ===== hdl/gcc_pkg.sv =====
// Package with the register indexes and fixed widths of the greedy coin change block.
package gcc_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int COUNT_W   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_DENOM_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DENOM_0     = 3'd1;

endpackage

// ===== hdl/gcc_amount_if.sv =====
// Stream interface that carries the amount to be paid out.
interface gcc_amount_if #(
  parameter int W = 16
);
  logic         valid;
  logic         ready;
  logic [W-1:0] amount;

  modport source (output valid, output amount, input ready);
  modport sink (input valid, input amount, output ready);
endinterface

// ===== hdl/gcc_coin_if.sv =====
// Stream interface that carries one coin result per denomination.
interface gcc_coin_if #(
  parameter int W = 16
);
  logic         valid;
  logic         ready;
  logic [W-1:0] coin_value;
  logic [W-1:0] coin_count;
  logic         last_flag;
  logic [W-1:0] total_coins;
  logic         short_flag;

  modport source (output valid, output coin_value, output coin_count, output last_flag,
                  output total_coins, output short_flag, input ready);
  modport sink (input valid, input coin_value, input coin_count, input last_flag,
                input total_coins, input short_flag, output ready);
endinterface

// ===== hdl/greedy_coin_change.sv =====
// Top level of the greedy coin change block.
// Each amount is split greedily over the denominations in use, largest first, with
// equal values kept in register order. For every denomination a comparator scan over
// the registers picks the largest one not yet used, then a restoring divider produces
// one quotient bit per cycle, and the result is loaded into the output register. A
// transaction runs every denomination through the single scan comparator and the
// single divider in turn. A stalled output adds its stall time. The next amount is
// taken once the last result is in the output register.
`include "greedy_coin_change_macros.svh"

module greedy_coin_change import gcc_pkg::*; #(
  parameter int MAX_DENOMS  = 6,
  parameter int VALUE_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [VALUE_WIDTH-1:0] cfg_data_i,
  gcc_amount_if.sink             in_i,
  gcc_coin_if.source             out_o
);

  localparam int IDX_W = (MAX_DENOMS > 1) ? $clog2(MAX_DENOMS) : 1;
  localparam int CNT_W = $clog2(MAX_DENOMS + 1);
  localparam int DIV_W = $clog2(VALUE_WIDTH);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_EMIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  logic [COUNT_W-1:0]     cfg_count_q;
  logic [VALUE_WIDTH-1:0] denom_q [MAX_DENOMS];

  logic [CNT_W-1:0]       cnt_q;
  logic [CNT_W-1:0]       emit_n_q;
  logic [MAX_DENOMS-1:0]  used_q;
  logic [IDX_W-1:0]       k_q;
  logic                   have_q;
  logic [IDX_W-1:0]       best_idx_q;
  logic [VALUE_WIDTH-1:0] best_val_q;
  logic [VALUE_WIDTH-1:0] rem_q;
  logic [VALUE_WIDTH-1:0] p_q;
  logic [VALUE_WIDTH-1:0] q_q;
  logic [DIV_W-1:0]       div_cnt_q;
  logic [VALUE_WIDTH-1:0] total_q;

  logic                   out_valid_q;
  logic [VALUE_WIDTH-1:0] out_value_q;
  logic [VALUE_WIDTH-1:0] out_count_q;
  logic                   out_last_q;
  logic [VALUE_WIDTH-1:0] out_total_q;
  logic                   out_short_q;

  logic                   accept;
  logic [CNT_W-1:0]       eff_cnt;
  logic [VALUE_WIDTH-1:0] scan_val;
  logic                   take;
  logic [IDX_W-1:0]       cand_idx;
  logic [VALUE_WIDTH-1:0] cand_val;
  logic                   scan_end;
  logic [VALUE_WIDTH:0]   trial;
  logic                   ge;
  logic [VALUE_WIDTH-1:0] p_next;
  logic [VALUE_WIDTH-1:0] q_next;
  logic                   div_end;
  logic                   emit_last;
  logic                   emit_load;
  logic [VALUE_WIDTH-1:0] total_sum;

  assign accept = (state_q == ST_IDLE) && in_i.valid;

  always_comb begin
    if (cfg_count_q == '0) begin
      eff_cnt = CNT_W'(1);
    end else if (cfg_count_q > COUNT_W'(MAX_DENOMS)) begin
      eff_cnt = CNT_W'(MAX_DENOMS);
    end else begin
      eff_cnt = CNT_W'(cfg_count_q);
    end
  end

  assign scan_val = denom_q[k_q];
  assign take     = !used_q[k_q] && (!have_q || (scan_val > best_val_q));
  assign cand_idx = take ? k_q : best_idx_q;
  assign cand_val = take ? scan_val : best_val_q;
  assign scan_end = (CNT_W'(k_q) + CNT_W'(1)) == cnt_q;

  assign trial   = {p_q, q_q[VALUE_WIDTH-1]};
  assign ge      = trial >= {1'b0, best_val_q};
  assign p_next  = ge ? VALUE_WIDTH'(trial - {1'b0, best_val_q}) : trial[VALUE_WIDTH-1:0];
  assign q_next  = {q_q[VALUE_WIDTH-2:0], ge};
  assign div_end = div_cnt_q == DIV_W'(VALUE_WIDTH - 1);

  assign emit_last = (emit_n_q + CNT_W'(1)) == cnt_q;
  assign emit_load = (state_q == ST_EMIT) && (!out_valid_q || out_o.ready);
  assign total_sum = total_q + q_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_d = (cand_val == '0) ? ST_EMIT : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_end) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (emit_load) begin
          state_d = emit_last ? ST_IDLE : ST_SCAN;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cfg_count_q <= COUNT_W'(1);
      for (int i = 0; i < MAX_DENOMS; i++) begin
        denom_q[i] <= VALUE_WIDTH'(1);
      end
      cnt_q       <= '0;
      emit_n_q    <= '0;
      used_q      <= '0;
      k_q         <= '0;
      have_q      <= 1'b0;
      div_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i && (cfg_idx_i == REG_DENOM_COUNT)) begin
        cfg_count_q <= cfg_data_i[COUNT_W-1:0];
      end
      for (int i = 0; i < MAX_DENOMS; i++) begin
        if (cfg_we_i && (cfg_idx_i == CFG_IDX_W'(int'(REG_DENOM_0) + i))) begin
          denom_q[i] <= cfg_data_i;
        end
      end

      if (accept) begin
        cnt_q    <= eff_cnt;
        emit_n_q <= '0;
        used_q   <= '0;
        k_q      <= '0;
        have_q   <= 1'b0;
      end

      if (state_q == ST_SCAN) begin
        if (take) begin
          have_q <= 1'b1;
        end
        if (!scan_end) begin
          k_q <= k_q + IDX_W'(1);
        end
        div_cnt_q <= '0;
      end

      if (state_q == ST_DIV) begin
        div_cnt_q <= div_cnt_q + DIV_W'(1);
      end

      if (emit_load) begin
        used_q[best_idx_q] <= 1'b1;
        emit_n_q           <= emit_n_q + CNT_W'(1);
        k_q                <= '0;
        have_q             <= 1'b0;
        out_valid_q        <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rem_q   <= in_i.amount;
      total_q <= '0;
    end
    if (state_q == ST_SCAN) begin
      best_idx_q <= cand_idx;
      best_val_q <= cand_val;
      p_q        <= '0;
      q_q        <= (scan_end && (cand_val == '0)) ? '0 : rem_q;
    end
    if (state_q == ST_DIV) begin
      p_q <= p_next;
      q_q <= q_next;
      if (div_end) begin
        rem_q <= p_next;
      end
    end
    if (emit_load) begin
      total_q     <= total_sum;
      out_value_q <= best_val_q;
      out_count_q <= q_q;
      out_last_q  <= emit_last;
      out_total_q <= emit_last ? total_sum : '0;
      out_short_q <= emit_last && (rem_q != '0);
    end
  end

  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.coin_value  = out_value_q;
  assign out_o.coin_count  = out_count_q;
  assign out_o.last_flag   = out_last_q;
  assign out_o.total_coins = out_total_q;
  assign out_o.short_flag  = out_short_q;

  `GCC_ASSERT(a_used_tracks_emits, clk_i, rst_ni, $countones(used_q) == int'(emit_n_q), "used mask and emit count disagree")
  `GCC_ASSERT_IMPL(a_div_partial_below_divisor, clk_i, rst_ni, state_q == ST_DIV, p_q < best_val_q, "divider partial remainder not below divisor")
  `GCC_ASSERT_IMPL(a_scan_in_range, clk_i, rst_ni, state_q == ST_SCAN, CNT_W'(k_q) < cnt_q, "scan index beyond denomination count")
  `GCC_ASSERT_IMPL(a_totals_only_on_last, clk_i, rst_ni, out_valid_q && !out_last_q, (out_total_q == '0) && !out_short_q, "total or short flag on a result that is not last")

endmodule
